// File: rtl/kare_pkg.sv
package kare_pkg;

	localparam int KEY_W       = 8;
	localparam int ST_W        = 2;
	localparam int EV_W        = 3;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int ENTRIES_DEF = 10;
	localparam int QDEPTH      = 2;   // power of two, pointers wrap naturally

	localparam logic             OP_EVENT      = 1'b0;
	localparam logic             OP_TICK       = 1'b1;
	localparam logic [ST_W-1:0]  ST_HOLD       = 2'd2;
	localparam logic [ST_W-1:0]  ST_RELEASED   = 2'd3;
	localparam logic [EV_W-1:0]  EV_AUTOREPEAT = 3'd4;
	localparam logic [CFG_W-1:0] COUNT_MAX     = {CFG_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd2;

	typedef enum logic [2:0] {
		CMD_EVENT   = 3'd0,
		CMD_HOLD    = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_TICK    = 3'd3,
		CMD_DROP    = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [KEY_W-1:0]  key;
		logic [ST_W-1:0]   state;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] repeat_iv;
		logic [CFG_W-1:0] fast_iv;
		logic [CFG_W-1:0] fast_dly;
	} cfg_t;

	typedef struct packed {
		logic             strobe;
		logic [KEY_W-1:0] key;
		logic [EV_W-1:0]  code;
		logic             last;
	} result_t;

endpackage

// File: rtl/kare_front.sv
module kare_front
	import kare_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  logic [KEY_W-1:0]  key_code,
	input  logic [ST_W-1:0]   key_state,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              rep_on,
	output logic              busy,
	output logic              item_valid,
	output item_t             item,
	input  logic              pop
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	item_t              fifo_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	cmd_t               cmd;
	logic               push;
	logic               take;

	// classify: ticks with repeat off are dropped, table ops only when repeat is on
	always_comb begin
		cmd = CMD_EVENT;
		if (op == OP_TICK) begin
			cmd = rep_on ? CMD_TICK : CMD_DROP;
		end else if (rep_on && key_code != '0) begin
			if (key_state == ST_HOLD) begin
				cmd = CMD_HOLD;
			end else if (key_state == ST_RELEASED) begin
				cmd = CMD_RELEASE;
			end
		end
	end

	assign busy       = (cnt_q == CNT_W'(QDEPTH));
	assign push       = start && !busy && (cmd != CMD_DROP);
	assign item_valid = (cnt_q != '0);
	assign take       = pop && item_valid;
	assign item       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{cmd: cmd, key: key_code, state: key_state, now: now_ms};
		end
	end

endmodule

// File: rtl/kare_back.sv
module kare_back
	import kare_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    clear,
	input  logic    item_valid,
	input  item_t   item,
	output logic    pop,
	output result_t res
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t             state_q;
	item_t              cur_q;
	logic [IDX_W-1:0]   idx_q;
	logic               pend_vld_q;
	logic [KEY_W-1:0]   pend_key_q;
	result_t            res_q;
	logic [KEY_W-1:0]   slot_key_q   [ENTRIES];
	logic [TIME_W-1:0]  slot_stamp_q [ENTRIES];
	logic [CFG_W-1:0]   slot_rep_q   [ENTRIES];

	logic [KEY_W-1:0]   sel_key;
	logic [TIME_W-1:0]  sel_stamp;
	logic [CFG_W-1:0]   sel_rep;
	logic [TIME_W-1:0]  elapsed;
	logic               slow;
	logic               fire;
	logic               last_slot;
	logic               wr_slot;
	logic [TIME_W-1:0]  wr_stamp;
	logic [CFG_W-1:0]   wr_rep;

	assign sel_key   = slot_key_q[idx_q];
	assign sel_stamp = slot_stamp_q[idx_q];
	assign sel_rep   = slot_rep_q[idx_q];
	assign elapsed   = cur_q.now - sel_stamp;
	assign slow      = (cfg.fast_dly == '0) || (sel_rep < cfg.fast_dly);
	assign last_slot = (idx_q == IDX_W'(ENTRIES - 1));
	assign pop       = (state_q == S_IDLE);
	assign res       = res_q;

	always_comb begin
		if (sel_key == '0) begin
			fire = 1'b0;
		end else if (slow) begin
			fire = elapsed > TIME_W'(cfg.repeat_iv);
		end else begin
			fire = (cfg.fast_iv != '0) && (elapsed > TIME_W'(cfg.fast_iv));
		end
	end

	// stamp and count writes for the slot under the scan index
	always_comb begin
		wr_slot  = 1'b0;
		wr_stamp = cur_q.now;
		wr_rep   = sel_rep;
		if (state_q == S_SCAN) begin
			case (cur_q.cmd)
				CMD_HOLD: begin
					wr_slot  = (sel_key == '0);
					wr_stamp = cur_q.now + TIME_W'(cfg.repeat_iv);
					wr_rep   = '0;
				end
				CMD_TICK: begin
					wr_slot = fire;
					if (cfg.fast_iv != '0 && sel_rep != COUNT_MAX) begin
						wr_rep = sel_rep + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_slot) begin
			slot_stamp_q[idx_q] <= wr_stamp;
			slot_rep_q[idx_q]   <= wr_rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= '0;
			idx_q      <= '0;
			pend_vld_q <= 1'b0;
			pend_key_q <= '0;
			res_q      <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_key_q[i] <= '0;
			end
		end else begin
			res_q.strobe <= 1'b0;
			if (clear) begin
				for (int i = 0; i < ENTRIES; i++) begin
					slot_key_q[i] <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cur_q <= item;
						idx_q <= '0;
						if (item.cmd != CMD_TICK) begin
							res_q.strobe <= 1'b1;
							res_q.key    <= item.key;
							res_q.code   <= EV_W'(item.state);
							res_q.last   <= 1'b1;
						end
						if (item.cmd != CMD_EVENT) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					case (cur_q.cmd)
						CMD_HOLD: begin
							if (sel_key == '0) begin
								slot_key_q[idx_q] <= cur_q.key;
								state_q           <= S_IDLE;
							end else if (last_slot) begin
								state_q <= S_IDLE;
							end
						end
						CMD_RELEASE: begin
							if (sel_key == cur_q.key) begin
								slot_key_q[idx_q] <= '0;
								state_q           <= S_IDLE;
							end else if (last_slot) begin
								state_q <= S_IDLE;
							end
						end
						CMD_TICK: begin
							// hold one fired key back so the final one can carry last
							if (fire) begin
								if (pend_vld_q) begin
									res_q.strobe <= 1'b1;
									res_q.key    <= pend_key_q;
									res_q.code   <= EV_AUTOREPEAT;
									res_q.last   <= 1'b0;
								end
								pend_vld_q <= 1'b1;
								pend_key_q <= sel_key;
							end
							if (last_slot) begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_DONE: begin
					if (pend_vld_q) begin
						res_q.strobe <= 1'b1;
						res_q.key    <= pend_key_q;
						res_q.code   <= EV_AUTOREPEAT;
						res_q.last   <= 1'b1;
					end
					pend_vld_q <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/key_auto_repeat_engine.sv
// Typematic auto-repeat engine. Items enter on start while busy is low and
// sit in a two-entry queue, so busy rises only when that queue is full. The
// execution side takes one item at a time: a key event is echoed in the
// cycle after it leaves the queue (last set); a HOLD or RELEASE then walks
// the slot table one slot per cycle until it finds its slot or reaches the
// last one; a tick walks all ENTRIES slots one per cycle through a single
// subtract-and-compare unit and closes with a flush step. Autorepeat
// results come out at most one per cycle in slot order, each delayed until
// the next firing slot or the end of the scan so that the final one carries
// last. Results are shown on strobe for exactly one cycle and cannot be
// held off: capture them when strobe is high. Ticks that arrive while
// repeat_interval is zero are dropped at the input and produce nothing.
// Configuration writes are always taken; write only while no item is in
// flight. Writing repeat_interval empties the table in the same cycle.
module key_auto_repeat_engine
	import kare_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [KEY_W-1:0]     key_code,
	input  logic [ST_W-1:0]      key_state,
	input  logic [TIME_W-1:0]    now_ms,
	output logic                 strobe,
	output logic [KEY_W-1:0]     out_key,
	output logic [EV_W-1:0]      event_code,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	logic    cfg_wr;
	logic    clear;
	logic    item_valid;
	item_t   item;
	logic    pop;
	result_t res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// any write of the slow period empties the table
	assign clear     = cfg_wr && (cfg_index == REG_REPEAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_REPEAT: cfg_q.repeat_iv <= cfg_data;
				REG_FAST:   cfg_q.fast_iv   <= cfg_data;
				REG_DELAY:  cfg_q.fast_dly  <= cfg_data;
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// front: accept, classify, queue
	kare_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.key_code   (key_code),
		.key_state  (key_state),
		.now_ms     (now_ms),
		.rep_on     (cfg_q.repeat_iv != '0),
		.busy       (busy),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop)
	);

	// back: echo events, update and scan the slot table
	kare_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clear      (clear),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.res        (res)
	);

	assign strobe     = res.strobe;
	assign out_key    = res.key;
	assign event_code = res.code;
	assign last       = res.last;

	// a forwarded key event is always the only result of its item
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && event_code != EV_AUTOREPEAT |-> last)
		else $error("key event result without last");

	// an autorepeat can only come from an occupied slot
	a_rep_key: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && event_code == EV_AUTOREPEAT |-> out_key != '0)
		else $error("autorepeat from a free slot");

	// emitted codes stay within the defined set
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> event_code <= EV_AUTOREPEAT)
		else $error("undefined event code");

endmodule
